>>> hdl/pdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pair distance histogram package
// Shared command codes, register indexes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package pdh_pkg;

  localparam logic [1:0] CMD_PAIR  = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] MODE_ATOM = 2'd0;
  localparam logic [1:0] MODE_MOL  = 2'd1;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_MAXSQ = 2'd1;
  localparam logic [1:0] REG_INVSP = 2'd2;
  localparam logic [1:0] REG_BINS  = 2'd3;

  localparam int unsigned DIFF_BITS  = 22;
  localparam int unsigned DSQ_BITS   = 46;
  localparam int unsigned ROOT_BITS  = 23;
  localparam int unsigned MAXSQ_BITS = 44;
  localparam int unsigned INVSP_BITS = 24;
  localparam int unsigned ADDR_BITS  = 10;
  localparam int unsigned CNT_BITS   = 32;
  localparam int unsigned NBINS_BITS = 11;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture input item
    logic sq_start;  // start squaring/summing
    logic sq_step;   // advance one squaring step
    logic rt_start;  // start root iteration
    logic rt_step;   // one root iteration
    logic scale;     // scale root to bin
    logic rd;        // issue memory read
    logic wr;        // write incremented count
    logic clr;       // clear sweep write
    logic result;    // capture result
  } pdh_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_pair;
    logic is_read;
    logic keep;      // pair passes exclusion and range
    logic in_range;  // bin below limit
    logic rt_done;
    logic clr_done;
  } pdh_stat_t;

endpackage
`default_nettype wire

>>> hdl/pair_distance_histogram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pair distance histogram
// Bins point-pair distances into a saturating histogram.
// ----------------------------------------------------------------------------
// Usage: input items arrive on in_valid/in_stall; command 0 bins a pair,
// 1 ends a frame, 2 reads a bin. Each item gives one result on
// out_valid/out_stall with counted, bin_hit, bin_count and frames_seen.
// The user must write configuration on cfg_valid/cfg_ready with cfg_index/
// cfg_data only while the block is idle; the block does not enforce it.
// Steps: a binned pair passes through three squaring steps, 23 square root
// iterations (one root bit per iteration), scaling and a read-modify-write
// of the histogram memory; a pair that lands beyond the bins skips the
// memory update, and a pair dropped by exclusion or range ends after the
// squaring steps. Other commands skip the squaring, root and scaling.
// One item is in work at a time, so a new item can be taken in the cycle
// after a result is stored; no item is taken before the last is through.
// After reset the histogram memory is cleared, one bin per cycle;
// in_stall stays high meanwhile.
// When the receiver stalls, the result holds in the output register; the
// next item may be accepted and worked on, but its result waits.
// ----------------------------------------------------------------------------
module pair_distance_histogram #(
  parameter int unsigned NBINS      = 1024,
  parameter int unsigned COORD_BITS = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    command,
  input  wire logic signed [COORD_BITS-1:0]  ax,
  input  wire logic signed [COORD_BITS-1:0]  ay,
  input  wire logic signed [COORD_BITS-1:0]  az,
  input  wire logic signed [COORD_BITS-1:0]  bx,
  input  wire logic signed [COORD_BITS-1:0]  by_coord,
  input  wire logic signed [COORD_BITS-1:0]  bz,
  input  wire logic [23:0]                   atom_a,
  input  wire logic [23:0]                   atom_b,
  input  wire logic [23:0]                   mol_a,
  input  wire logic [23:0]                   mol_b,
  input  wire logic [9:0]                    bin_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               counted,
  output logic [9:0]                         bin_hit,
  output logic [31:0]                        bin_count,
  output logic [31:0]                        frames_seen,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [63:0]                   cfg_data
);
  import pdh_pkg::*;

  pdh_cmd_t  cmd;
  pdh_stat_t stat;

  assign cfg_ready = 1'b1;

  pdh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pdh_dpath #(
    .NBINS      (NBINS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .command     (command),
    .ax          (ax),
    .ay          (ay),
    .az          (az),
    .bx          (bx),
    .by_coord    (by_coord),
    .bz          (bz),
    .atom_a      (atom_a),
    .atom_b      (atom_b),
    .mol_a       (mol_a),
    .mol_b       (mol_b),
    .bin_index   (bin_index),
    .counted     (counted),
    .bin_hit     (bin_hit),
    .bin_count   (bin_count),
    .frames_seen (frames_seen)
  );

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.clr |-> in_stall) else $error("item accepted during clear");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    cmd.result |=> out_valid) else $error("result not presented");

  a_counted_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !counted) |-> (bin_hit == '0)) else $error("bin_hit without count");

  a_frames_mono: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (frames_seen >= $past(frames_seen)))
    else $error("frame counter went back");

endmodule
`default_nettype wire

>>> hdl/pdh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pair distance histogram controller
// Sequences clearing, distance, root, binning and result transfer.
// ----------------------------------------------------------------------------
module pdh_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire pdh_pkg::pdh_stat_t stat,
  output pdh_pkg::pdh_cmd_t      cmd
);
  import pdh_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SQ0   = 4'd2;
  localparam logic [3:0] S_SQ1   = 4'd3;
  localparam logic [3:0] S_SQ2   = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_ROOT  = 4'd6;
  localparam logic [3:0] S_SCALE = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_WAIT  = 4'd9;
  localparam logic [3:0] S_WR    = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state, state_next;
  logic       out_full;

  wire take = in_valid && !in_stall;
  wire give = out_valid && !out_stall;

  // One item at a time; the output register lets the next item enter
  // while a result still waits.
  assign in_stall  = (state != S_IDLE);
  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.result) begin
      out_full <= 1'b1;
    end else if (give) begin
      out_full <= 1'b0;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          cmd.load = 1'b1;
          state_next = S_SQ0;
        end
      end
      S_SQ0: begin
        if (stat.is_pair) begin
          cmd.sq_start = 1'b1;
          state_next = S_SQ1;
        end else begin
          cmd.rd = stat.is_read;
          state_next = S_WAIT;
        end
      end
      S_SQ1: begin
        cmd.sq_step = 1'b1;
        state_next = S_SQ2;
      end
      S_SQ2: begin
        cmd.sq_step = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.keep) begin
          cmd.rt_start = 1'b1;
          state_next = S_ROOT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_ROOT: begin
        cmd.rt_step = 1'b1;
        if (stat.rt_done) state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        if (stat.in_range) begin
          cmd.rd = 1'b1;
          state_next = S_WR;
        end else begin
          state_next = S_OUT;
        end
      end
      S_WR: begin
        cmd.wr = 1'b1;
        state_next = S_OUT;
      end
      S_WAIT: state_next = S_OUT;
      S_OUT: begin
        // The finished result waits here until the output register is free.
        if (!out_full || give) begin
          cmd.result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/pdh_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pair distance histogram datapath
// Squared distance, iterative root, bin scaling, histogram memory, counters.
// ----------------------------------------------------------------------------
module pdh_dpath #(
  parameter int unsigned NBINS      = 1024,
  parameter int unsigned COORD_BITS = 20
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire pdh_pkg::pdh_cmd_t                    cmd,
  output pdh_pkg::pdh_stat_t                        stat,
  input  wire logic                                 cfg_we,
  input  wire logic [1:0]                           cfg_index,
  input  wire logic [63:0]                          cfg_data,
  input  wire logic [1:0]                           command,
  input  wire logic signed [COORD_BITS-1:0]         ax,
  input  wire logic signed [COORD_BITS-1:0]         ay,
  input  wire logic signed [COORD_BITS-1:0]         az,
  input  wire logic signed [COORD_BITS-1:0]         bx,
  input  wire logic signed [COORD_BITS-1:0]         by_coord,
  input  wire logic signed [COORD_BITS-1:0]         bz,
  input  wire logic [23:0]                          atom_a,
  input  wire logic [23:0]                          atom_b,
  input  wire logic [23:0]                          mol_a,
  input  wire logic [23:0]                          mol_b,
  input  wire logic [pdh_pkg::ADDR_BITS-1:0]        bin_index,
  output logic                                      counted,
  output logic [pdh_pkg::ADDR_BITS-1:0]             bin_hit,
  output logic [pdh_pkg::CNT_BITS-1:0]              bin_count,
  output logic [pdh_pkg::CNT_BITS-1:0]              frames_seen
);
  import pdh_pkg::*;

  localparam int unsigned AW = (NBINS > 1) ? $clog2(NBINS) : 1;
  localparam int unsigned WB = COORD_BITS + 1;
  localparam int unsigned RT_ITERS = ROOT_BITS;
  localparam int unsigned IW = $clog2(RT_ITERS + 1);
  // The bound is clipped to 4095 so that it fits the NBINS_BITS+1 bit width.
  localparam logic [NBINS_BITS:0] NB = (NBINS_BITS + 1)'((NBINS < 4095) ? NBINS : 4095);

  // Configuration registers.
  logic [1:0]            pair_mode;
  logic [MAXSQ_BITS-1:0] max_dist_sq;
  logic [INVSP_BITS-1:0] inv_spacing;
  logic [NBINS_BITS-1:0] bins_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_mode   <= '0;
      max_dist_sq <= '0;
      inv_spacing <= '0;
      bins_in_use <= NBINS_BITS'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  pair_mode   <= cfg_data[1:0];
        REG_MAXSQ: max_dist_sq <= cfg_data[MAXSQ_BITS-1:0];
        REG_INVSP: inv_spacing <= cfg_data[INVSP_BITS-1:0];
        REG_BINS:  bins_in_use <= cfg_data[NBINS_BITS-1:0];
        default:   ;
      endcase
    end
  end

  // Captured item.
  logic [1:0]           cmd_q;
  logic                 skip;
  logic [WB-1:0]        dx, dy, dz;
  logic [ADDR_BITS-1:0] rd_index;

  function automatic logic [WB-1:0] absd(input logic signed [COORD_BITS-1:0] a,
                                         input logic signed [COORD_BITS-1:0] b);
    logic signed [WB-1:0] d;
    d = WB'(a) - WB'(b);
    return d[WB-1] ? WB'(-d) : WB'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q    <= command;
      dx       <= absd(ax, bx);
      dy       <= absd(ay, by_coord);
      dz       <= absd(az, bz);
      rd_index <= bin_index;
      unique case (pair_mode)
        MODE_ATOM: skip <= (atom_a == atom_b);
        MODE_MOL:  skip <= (mol_a == mol_b);
        default:   skip <= 1'b0;
      endcase
    end
  end

  // Sum of squares, one WB x WB (COORD_BITS+1 bit) product per cycle.
  logic [1:0]          sq_sel;
  logic [DSQ_BITS-1:0] d2;
  logic                huge;
  logic [WB-1:0]       sq_op;
  logic [DSQ_BITS-1:0] sq_prod;

  always_comb begin
    case (sq_sel)
      2'd0:    sq_op = dx;
      2'd1:    sq_op = dy;
      default: sq_op = dz;
    endcase
    sq_prod = DSQ_BITS'(sq_op) * DSQ_BITS'(sq_op);
  end

  wire big_x = (DIFF_BITS < WB) ? (DSQ_BITS'(dx) >> DIFF_BITS) != '0 : 1'b0;
  wire big_y = (DIFF_BITS < WB) ? (DSQ_BITS'(dy) >> DIFF_BITS) != '0 : 1'b0;
  wire big_z = (DIFF_BITS < WB) ? (DSQ_BITS'(dz) >> DIFF_BITS) != '0 : 1'b0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq_sel <= 2'd0;
    end else if (cmd.sq_start) begin
      d2     <= sq_prod;
      sq_sel <= 2'd1;
      huge   <= big_x || big_y || big_z;
    end else if (cmd.sq_step) begin
      d2     <= d2 + sq_prod;
      sq_sel <= sq_sel + 2'd1;
    end
  end

  assign stat.is_pair = (cmd_q == CMD_PAIR);
  assign stat.is_read = (cmd_q == CMD_READ);
  assign stat.keep    = !skip && !huge && (d2 <= DSQ_BITS'(max_dist_sq));

  // Restoring square root, one result bit per cycle.
  logic [DSQ_BITS-1:0]  rem;
  logic [ROOT_BITS-1:0] root;
  logic [IW-1:0]        rt_cnt;
  logic [DSQ_BITS-1:0]  rt_src;
  logic [DSQ_BITS+1:0]  rt_trial;
  logic [DSQ_BITS+1:0]  rt_part;

  always_comb begin
    rt_part  = {rem, rt_src[DSQ_BITS-1 -: 2]};
    rt_trial = (DSQ_BITS + 2)'({root, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (cmd.rt_start) begin
      rem    <= '0;
      root   <= '0;
      rt_src <= d2;
      rt_cnt <= '0;
    end else if (cmd.rt_step) begin
      rt_src <= rt_src << 2;
      rt_cnt <= rt_cnt + IW'(1);
      if (rt_part >= rt_trial) begin
        rem  <= DSQ_BITS'(rt_part - rt_trial);
        root <= {root[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem  <= DSQ_BITS'(rt_part);
        root <= {root[ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  assign stat.rt_done = (rt_cnt == IW'(RT_ITERS - 1));

  // Scale root by inverse spacing.
  logic [ROOT_BITS+INVSP_BITS-1:0] prod;
  logic [ROOT_BITS+INVSP_BITS-25:0] idx;
  logic [NBINS_BITS:0] limit;

  always_ff @(posedge clk) begin
    if (cmd.scale) prod <= (ROOT_BITS+INVSP_BITS)'(root) * (ROOT_BITS+INVSP_BITS)'(inv_spacing);
  end

  assign idx   = prod[ROOT_BITS+INVSP_BITS-1:24];
  assign limit = ((NBINS_BITS+1)'(bins_in_use) < NB) ? (NBINS_BITS+1)'(bins_in_use) : NB;
  assign stat.in_range = (idx < (ROOT_BITS+INVSP_BITS-24)'(limit));

  // Histogram memory with clearing sweep after reset.
  logic [CNT_BITS-1:0] mem [NBINS];
  logic [CNT_BITS-1:0] rd_data;
  logic [AW-1:0]       clr_addr;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic                rd_ok;

  assign stat.clr_done = (clr_addr == AW'(NBINS - 1));
  assign rd_addr = stat.is_read ? AW'(rd_index) : AW'(idx);
  assign rd_ok   = (32'(rd_index) < 32'(NBINS));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr && !stat.clr_done) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
      wr_addr <= rd_addr;
    end
    if (cmd.clr) begin
      mem[clr_addr] <= '0;
    end else if (cmd.wr) begin
      mem[wr_addr] <= (rd_data == CNT_MAX) ? rd_data : rd_data + CNT_BITS'(1);
    end
  end

  // Frame counter and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_seen <= '0;
    end else if (cmd.result && cmd_q == CMD_FRAME && frames_seen != CNT_MAX) begin
      frames_seen <= frames_seen + CNT_BITS'(1);
    end
  end

  wire hit_now = stat.is_pair && stat.keep && stat.in_range;

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      counted   <= hit_now;
      bin_hit   <= hit_now ? ADDR_BITS'(idx) : '0;
      bin_count <= (stat.is_read && rd_ok) ? rd_data : '0;
    end
  end

endmodule
`default_nettype wire
